/* rtl/core/aefm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and tables of the attitude error fin mixer.
package aefm_pkg;

   localparam int QUAT_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int ZW    = 25;
   localparam int ANG_W = ZW - 8;
   localparam logic signed [ZW-1:0] DEG180 = 25'sd5898240;

   localparam logic signed [ANG_W-1:0] ROLL_LIM  = 17'sd23040;
   localparam logic signed [ANG_W-1:0] PITCH_LIM = 17'sd11520;

   localparam logic [11:0] PULSE_MIN = 12'd500;
   localparam logic [11:0] PULSE_MAX = 12'd2500;
   localparam logic [11:0] PULSE_RST = 12'd1500;
   localparam logic [10:0] NEUTRAL_RST = 11'd1500;
   localparam logic [3:0]  GAIN_RST    = 4'd2;

   typedef enum logic [1:0] {
      MODE_EMPTY  = 2'd0,
      MODE_INIT   = 2'd1,
      MODE_ASCENT = 2'd2,
      MODE_SAFE   = 2'd3
   } mode_type;

   localparam logic CSR_NEUTRAL = 1'b0;
   localparam logic CSR_GAIN    = 1'b1;

   localparam int OPW  = 5;
   localparam int NOPS = 26;

   localparam logic [3:0] SRC_IW = 4'd0;
   localparam logic [3:0] SRC_IX = 4'd1;
   localparam logic [3:0] SRC_IY = 4'd2;
   localparam logic [3:0] SRC_IZ = 4'd3;
   localparam logic [3:0] SRC_RW = 4'd4;
   localparam logic [3:0] SRC_RX = 4'd5;
   localparam logic [3:0] SRC_RY = 4'd6;
   localparam logic [3:0] SRC_RZ = 4'd7;
   localparam logic [3:0] SRC_DW = 4'd8;
   localparam logic [3:0] SRC_DX = 4'd9;
   localparam logic [3:0] SRC_DY = 4'd10;
   localparam logic [3:0] SRC_DZ = 4'd11;

   localparam logic [3:0] DST_DW   = 4'd0;
   localparam logic [3:0] DST_DX   = 4'd1;
   localparam logic [3:0] DST_DY   = 4'd2;
   localparam logic [3:0] DST_DZ   = 4'd3;
   localparam logic [3:0] DST_SINR = 4'd4;
   localparam logic [3:0] DST_COSR = 4'd5;
   localparam logic [3:0] DST_SINP = 4'd6;
   localparam logic [3:0] DST_SINY = 4'd7;
   localparam logic [3:0] DST_COSY = 4'd8;

   typedef struct packed {
      logic [3:0] a;
      logic [3:0] b;
      logic       neg;
      logic       last;
      logic [3:0] dst;
   } mac_op_type;

   function automatic mac_op_type mk_op(input logic [3:0] a, input logic [3:0] b,
                                        input logic neg, input logic last,
                                        input logic [3:0] dst);
      mac_op_type o;
      o.a    = a;
      o.b    = b;
      o.neg  = neg;
      o.last = last;
      o.dst  = dst;
      return o;
   endfunction

   function automatic mac_op_type mac_op(input logic [OPW-1:0] idx);
      mac_op_type o;
      case (idx)
         5'd0:    o = mk_op(SRC_IW, SRC_RW, 1'b0, 1'b0, DST_DW);
         5'd1:    o = mk_op(SRC_IX, SRC_RX, 1'b0, 1'b0, DST_DW);
         5'd2:    o = mk_op(SRC_IY, SRC_RY, 1'b0, 1'b0, DST_DW);
         5'd3:    o = mk_op(SRC_IZ, SRC_RZ, 1'b0, 1'b1, DST_DW);
         5'd4:    o = mk_op(SRC_IW, SRC_RX, 1'b1, 1'b0, DST_DX);
         5'd5:    o = mk_op(SRC_IX, SRC_RW, 1'b0, 1'b0, DST_DX);
         5'd6:    o = mk_op(SRC_IY, SRC_RZ, 1'b0, 1'b0, DST_DX);
         5'd7:    o = mk_op(SRC_IZ, SRC_RY, 1'b1, 1'b1, DST_DX);
         5'd8:    o = mk_op(SRC_IW, SRC_RY, 1'b1, 1'b0, DST_DY);
         5'd9:    o = mk_op(SRC_IX, SRC_RZ, 1'b1, 1'b0, DST_DY);
         5'd10:   o = mk_op(SRC_IY, SRC_RW, 1'b0, 1'b0, DST_DY);
         5'd11:   o = mk_op(SRC_IZ, SRC_RX, 1'b0, 1'b1, DST_DY);
         5'd12:   o = mk_op(SRC_IW, SRC_RZ, 1'b1, 1'b0, DST_DZ);
         5'd13:   o = mk_op(SRC_IX, SRC_RY, 1'b0, 1'b0, DST_DZ);
         5'd14:   o = mk_op(SRC_IY, SRC_RX, 1'b1, 1'b0, DST_DZ);
         5'd15:   o = mk_op(SRC_IZ, SRC_RW, 1'b0, 1'b1, DST_DZ);
         5'd16:   o = mk_op(SRC_DW, SRC_DX, 1'b0, 1'b0, DST_SINR);
         5'd17:   o = mk_op(SRC_DY, SRC_DZ, 1'b0, 1'b1, DST_SINR);
         5'd18:   o = mk_op(SRC_DX, SRC_DX, 1'b0, 1'b0, DST_COSR);
         5'd19:   o = mk_op(SRC_DY, SRC_DY, 1'b0, 1'b1, DST_COSR);
         5'd20:   o = mk_op(SRC_DW, SRC_DY, 1'b0, 1'b0, DST_SINP);
         5'd21:   o = mk_op(SRC_DZ, SRC_DX, 1'b1, 1'b1, DST_SINP);
         5'd22:   o = mk_op(SRC_DW, SRC_DZ, 1'b0, 1'b0, DST_SINY);
         5'd23:   o = mk_op(SRC_DX, SRC_DY, 1'b0, 1'b1, DST_SINY);
         5'd24:   o = mk_op(SRC_DY, SRC_DY, 1'b0, 1'b0, DST_COSY);
         5'd25:   o = mk_op(SRC_DZ, SRC_DZ, 1'b0, 1'b1, DST_COSY);
         default: o = mk_op(SRC_IW, SRC_RW, 1'b0, 1'b1, DST_COSY);
      endcase
      return o;
   endfunction

   function automatic logic [ZW-1:0] atan_step(input logic [4:0] i);
      logic [ZW-1:0] a;
      case (i)
         5'd0:    a = 25'd1474560;
         5'd1:    a = 25'd870484;
         5'd2:    a = 25'd459940;
         5'd3:    a = 25'd233473;
         5'd4:    a = 25'd117189;
         5'd5:    a = 25'd58652;
         5'd6:    a = 25'd29333;
         5'd7:    a = 25'd14667;
         5'd8:    a = 25'd7334;
         5'd9:    a = 25'd3667;
         5'd10:   a = 25'd1833;
         5'd11:   a = 25'd917;
         5'd12:   a = 25'd458;
         5'd13:   a = 25'd229;
         5'd14:   a = 25'd115;
         5'd15:   a = 25'd57;
         5'd16:   a = 25'd29;
         5'd17:   a = 25'd14;
         5'd18:   a = 25'd7;
         5'd19:   a = 25'd4;
         5'd20:   a = 25'd2;
         5'd21:   a = 25'd1;
         default: a = 25'd0;
      endcase
      return a;
   endfunction

endpackage

/* rtl/core/attitude_error_fin_mixer_unit.sv */
`timescale 1ns / 1ps
// Attitude error fin mixer: quaternion error, Euler angles and fin pulse mixing.
// Ascent: the result is built from 27 products on one multiplier, three CORDIC runs and a
// 31-step square root; a saturated pitch skips the square root and the third CORDIC run, and a
// zero vector ends its CORDIC run at once. Other modes go straight to S_OUT, which loads the result.
// A new request is taken once the result loads, and not while it waits for the output register.
// Synchronous active-high reset: mode empty, identity reference, zero errors, 1500 us pulses.
module attitude_error_fin_mixer_unit #(
   parameter int QUAT_BITS    = aefm_pkg::QUAT_BITS_DEF,
   parameter int CORDIC_STEPS = aefm_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // requested_mode, quat_w, quat_x, quat_y, quat_z
   input  logic [((2+4*QUAT_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // active_mode, roll_error, pitch_error, yaw_error,
   // fin_px_us, fin_nx_us, fin_py_us, fin_ny_us
   output logic [103:0]                        rsp_tdata,
   input  logic                                csr_we,
   input  logic [0:0]                          csr_index,
   input  logic [10:0]                         csr_wdata
);

   localparam int QB  = QUAT_BITS;
   localparam int F   = QB - 2;
   localparam int DW  = QB + 4;
   localparam int AW  = 2*QB + 9;
   localparam int EW  = 2*QB + 10;
   localparam int CW  = EW + 3;
   localparam int MW  = (DW > 32) ? DW : 32;
   localparam int PW  = 2*MW;
   localparam int SW  = 32;
   localparam int RW  = 62;
   localparam int SDN = (2*F >= 30) ? 2*F - 30 : 0;
   localparam int SUP = (2*F >= 30) ? 0 : 30 - 2*F;
   localparam int ZW  = aefm_pkg::ZW;
   localparam int AGW = aefm_pkg::ANG_W;

   localparam logic signed [AW-1:0] RND_F = AW'(1) <<< (F-1);
   localparam logic signed [EW-1:0] ONE_Q = EW'(1) <<< (2*F);
   localparam logic signed [EW-1:0] RND_S = (EW'(1) <<< SDN) >>> 1;
   localparam logic [RW-1:0] SQ_ONE = RW'(1) << 60;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_MUL    = 11'b00000000010,
      S_ACC    = 11'b00000000100,
      S_CSTART = 11'b00000001000,
      S_CWAIT  = 11'b00000010000,
      S_PCHK   = 11'b00000100000,
      S_SQ     = 11'b00001000000,
      S_SQI    = 11'b00010000000,
      S_SQRT   = 11'b00100000000,
      S_FIN    = 11'b01000000000,
      S_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   aefm_pkg::mode_type mode_ff, mode_in, req_mode;
   logic signed [QB-1:0] ref_ff [4], ref_in [4];
   logic signed [QB-1:0] imu_ff [4], imu_in [4];
   logic signed [DW-1:0] dlt_ff [4], dlt_in [4];
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [aefm_pkg::OPW-1:0] op_ff, op_in;
   logic signed [EW-1:0] sinr_ff, sinr_in, cosr_ff, cosr_in, sinp_ff, sinp_in;
   logic signed [EW-1:0] siny_ff, siny_in, cosy_ff, cosy_in;
   logic [1:0] ang_ff, ang_in;
   logic signed [15:0] roll_ff, roll_in, yaw_ff, yaw_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic [11:0] fin_ff [4], fin_in [4];
   logic signed [SW-1:0] s_ff, s_in;
   logic [RW-1:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [10:0] neutral_ff, neutral_in;
   logic [3:0] gain_ff, gain_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [103:0] rsp_data_ff, rsp_data_in;

   aefm_pkg::mac_op_type op;
   logic signed [MW-1:0] src_val [12];
   logic signed [MW-1:0] ma, mb;
   logic signed [AW-1:0] p, sum;
   logic signed [EW-1:0] t2;
   logic signed [EW-1:0] sc;
   logic signed [SW-1:0] s_mag;
   logic [RW-1:0] trial;
   logic cstart, cdone;
   logic signed [CW-1:0] cy, cx;
   logic signed [ZW-1:0] cangle, zr;
   logic signed [AGW-1:0] ar, lim, ac;
   logic signed [12:0] off_r, off_p;
   logic accept;

   function automatic logic signed [12:0] fin_offset(input logic signed [20:0] v);
      logic [20:0] mag;
      logic [20:0] q;
      mag = v[20] ? 21'(-v) : 21'(v);
      q   = (mag + 21'd64) >> 7;
      fin_offset = v[20] ? -13'(q) : 13'(q);
   endfunction

   function automatic logic [11:0] fin_pulse(input logic [10:0] neutral,
                                             input logic signed [12:0] off,
                                             input logic sub);
      logic signed [13:0] t;
      t = $signed({3'b000, neutral}) + (sub ? -14'(off) : 14'(off));
      if (t < $signed(14'(aefm_pkg::PULSE_MIN)))
         fin_pulse = aefm_pkg::PULSE_MIN;
      else if (t > $signed(14'(aefm_pkg::PULSE_MAX)))
         fin_pulse = aefm_pkg::PULSE_MAX;
      else
         fin_pulse = 12'(t);
   endfunction

   aefm_cordic #(
      .CW    (CW),
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cstart),
      .y_in  (cy),
      .x_in  (cx),
      .done  (cdone),
      .angle (cangle)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_mode   = aefm_pkg::mode_type'(req_tdata[1:0]);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign op = aefm_pkg::mac_op(op_ff);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         src_val[k]     = MW'(imu_ff[k]);
         src_val[4 + k] = MW'(ref_ff[k]);
         src_val[8 + k] = MW'(dlt_ff[k]);
      end
   end

   assign s_mag = s_ff[SW-1] ? -s_ff : s_ff;
   assign ma    = (state_ff == S_SQ) ? MW'(s_mag) : src_val[op.a];
   assign mb    = (state_ff == S_SQ) ? MW'(s_mag) : src_val[op.b];

   assign p     = AW'(prod_ff);
   assign sum   = acc_ff + (op.neg ? -p : p);
   assign t2    = EW'(sum) <<< 1;
   assign sc    = ((sinp_ff + RND_S) >>> SDN) <<< SUP;
   assign trial = res_ff + bit_ff;

   assign zr = cangle + ZW'(128);
   assign ar = AGW'(zr >>> 8);

   always_comb begin
      case (ang_ff)
         2'd0:    begin cy = CW'(sinr_ff); cx = CW'(cosr_ff); end
         2'd1:    begin cy = CW'(siny_ff); cx = CW'(cosy_ff); end
         default: begin cy = CW'(s_ff);    cx = $signed(CW'(res_ff)); end
      endcase
      lim = (ang_ff == 2'd2) ? aefm_pkg::PITCH_LIM : aefm_pkg::ROLL_LIM;
      if (ar > lim)
         ac = lim;
      else if (ar < -lim)
         ac = -lim;
      else
         ac = ar;
   end

   assign off_r = fin_offset(21'(signed'({1'b0, gain_ff})) * 21'(roll_ff));
   assign off_p = fin_offset(21'(signed'({1'b0, gain_ff})) * 21'(pitch_ff));

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      ref_in       = ref_ff;
      imu_in       = imu_ff;
      dlt_in       = dlt_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      op_in        = op_ff;
      sinr_in      = sinr_ff;
      cosr_in      = cosr_ff;
      sinp_in      = sinp_ff;
      siny_in      = siny_ff;
      cosy_in      = cosy_ff;
      ang_in       = ang_ff;
      roll_in      = roll_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      fin_in       = fin_ff;
      s_in         = s_ff;
      v_in         = v_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      neutral_in   = neutral_ff;
      gain_in      = gain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cstart       = 1'b0;

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      if (csr_we) begin
         case (csr_index)
            aefm_pkg::CSR_NEUTRAL: neutral_in = csr_wdata;
            aefm_pkg::CSR_GAIN:    gain_in    = csr_wdata[3:0];
            default:               neutral_in = neutral_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               for (int k = 0; k < 4; k++)
                  imu_in[k] = $signed(req_tdata[2 + k*QB +: QB]);
               mode_in = req_mode;
               if (req_mode == aefm_pkg::MODE_INIT && mode_ff != aefm_pkg::MODE_INIT) begin
                  for (int k = 0; k < 4; k++)
                     ref_in[k] = $signed(req_tdata[2 + k*QB +: QB]);
               end
               if (req_mode == aefm_pkg::MODE_ASCENT) begin
                  op_in    = '0;
                  acc_in   = '0;
                  state_in = S_MUL;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_MUL: begin
            prod_in  = PW'(ma) * PW'(mb);
            state_in = S_ACC;
         end
         S_ACC: begin
            if (op.last) begin
               acc_in = '0;
               case (op.dst)
                  aefm_pkg::DST_DW:   dlt_in[0] = DW'((sum + RND_F) >>> F);
                  aefm_pkg::DST_DX:   dlt_in[1] = DW'((sum + RND_F) >>> F);
                  aefm_pkg::DST_DY:   dlt_in[2] = DW'((sum + RND_F) >>> F);
                  aefm_pkg::DST_DZ:   dlt_in[3] = DW'((sum + RND_F) >>> F);
                  aefm_pkg::DST_SINR: sinr_in = t2;
                  aefm_pkg::DST_COSR: cosr_in = ONE_Q - t2;
                  aefm_pkg::DST_SINP: sinp_in = t2;
                  aefm_pkg::DST_SINY: siny_in = t2;
                  aefm_pkg::DST_COSY: cosy_in = ONE_Q - t2;
                  default:            acc_in = '0;
               endcase
            end else begin
               acc_in = sum;
            end
            if (op_ff == aefm_pkg::OPW'(aefm_pkg::NOPS - 1)) begin
               ang_in   = 2'd0;
               state_in = S_CSTART;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_CSTART: begin
            cstart   = 1'b1;
            state_in = S_CWAIT;
         end
         S_CWAIT: begin
            if (cdone) begin
               case (ang_ff)
                  2'd0: begin
                     roll_in  = 16'(ac);
                     ang_in   = 2'd1;
                     state_in = S_CSTART;
                  end
                  2'd1: begin
                     yaw_in   = 16'(ac);
                     ang_in   = 2'd2;
                     state_in = S_PCHK;
                  end
                  default: begin
                     pitch_in = 15'(ac);
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_PCHK: begin
            if (sinp_ff >= ONE_Q) begin
               pitch_in = 15'(aefm_pkg::PITCH_LIM);
               state_in = S_FIN;
            end else if (sinp_ff <= -ONE_Q) begin
               pitch_in = 15'(-aefm_pkg::PITCH_LIM);
               state_in = S_FIN;
            end else begin
               s_in     = SW'(sc);
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            prod_in  = PW'(ma) * PW'(mb);
            state_in = S_SQI;
         end
         S_SQI: begin
            v_in     = SQ_ONE - RW'(prod_ff);
            res_in   = '0;
            bit_in   = SQ_ONE;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == RW'(1))
               state_in = S_CSTART;
         end
         S_FIN: begin
            fin_in[0] = fin_pulse(neutral_ff, off_r, 1'b0);
            fin_in[1] = fin_pulse(neutral_ff, off_r, 1'b1);
            fin_in[2] = fin_pulse(neutral_ff, off_p, 1'b0);
            fin_in[3] = fin_pulse(neutral_ff, off_p, 1'b1);
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, fin_ff[3], fin_ff[2], fin_ff[1], fin_ff[0],
                               yaw_ff, pitch_ff, roll_ff, mode_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= aefm_pkg::MODE_EMPTY;
         ref_ff[0]    <= QB'(1) <<< F;
         ref_ff[1]    <= '0;
         ref_ff[2]    <= '0;
         ref_ff[3]    <= '0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
         for (int k = 0; k < 4; k++)
            fin_ff[k] <= aefm_pkg::PULSE_RST;
         neutral_ff   <= aefm_pkg::NEUTRAL_RST;
         gain_ff      <= aefm_pkg::GAIN_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         ref_ff       <= ref_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
         fin_ff       <= fin_in;
         neutral_ff   <= neutral_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      imu_ff      <= imu_in;
      dlt_ff      <= dlt_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      op_ff       <= op_in;
      sinr_ff     <= sinr_in;
      cosr_ff     <= cosr_in;
      sinp_ff     <= sinp_in;
      siny_ff     <= siny_in;
      cosy_ff     <= cosy_in;
      ang_ff      <= ang_in;
      s_ff        <= s_in;
      v_ff        <= v_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/core/aefm_cordic.sv */
`timescale 1ns / 1ps
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
module aefm_cordic #(
   parameter int CW    = 45,
   parameter int STEPS = aefm_pkg::CORDIC_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [CW-1:0]             y_in,
   input  logic signed [CW-1:0]             x_in,
   output logic                             done,
   output logic signed [aefm_pkg::ZW-1:0]   angle
);

   localparam int ITW = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [ITW-1:0] LAST = ITW'(STEPS - 1);

   typedef enum logic [1:0] {
      C_IDLE = 2'b01,
      C_RUN  = 2'b10
   } cstate_type;

   cstate_type state_ff, state_in;
   logic done_ff, done_in;
   logic signed [CW-1:0] x_ff, x_in_nx, y_ff, y_in_nx;
   logic signed [aefm_pkg::ZW-1:0] z_ff, z_in;
   logic [ITW-1:0] it_ff, it_in;
   logic signed [CW-1:0] dx, dy;
   logic signed [aefm_pkg::ZW-1:0] tab;

   assign dx  = y_ff >>> it_ff;
   assign dy  = x_ff >>> it_ff;
   assign tab = $signed(aefm_pkg::atan_step(5'(it_ff)));

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      x_in_nx  = x_ff;
      y_in_nx  = y_ff;
      z_in     = z_ff;
      it_in    = it_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               it_in = '0;
               if (x_in == '0 && y_in == '0) begin
                  z_in    = '0;
                  done_in = 1'b1;
               end else if (x_in[CW-1]) begin
                  z_in     = y_in[CW-1] ? -aefm_pkg::DEG180 : aefm_pkg::DEG180;
                  x_in_nx  = -x_in;
                  y_in_nx  = -y_in;
                  state_in = C_RUN;
               end else begin
                  z_in     = '0;
                  x_in_nx  = x_in;
                  y_in_nx  = y_in;
                  state_in = C_RUN;
               end
            end
         end
         C_RUN: begin
            if (y_ff > 0) begin
               x_in_nx = x_ff + dx;
               y_in_nx = y_ff - dy;
               z_in    = z_ff + tab;
            end else begin
               x_in_nx = x_ff - dx;
               y_in_nx = y_ff + dy;
               z_in    = z_ff - tab;
            end
            if (it_ff == LAST) begin
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else begin
               it_in = it_ff + 1'b1;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in_nx;
      y_ff  <= y_in_nx;
      z_ff  <= z_in;
      it_ff <= it_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

/* tb/attitude_error_fin_mixer_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench of the attitude error fin mixer: predicts each result from mode, quaternion, gains.
module attitude_error_fin_mixer_unit_tb;

   localparam int QB = 16;
   localparam int FR = QB - 2;
   localparam int STEPS = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = aefm_pkg::CSR_NEUTRAL;
   logic [10:0] csr_wdata = '0;

   attitude_error_fin_mixer_unit uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // predictor state
   longint neutral_us, gain_us;
   aefm_pkg::mode_type mode_now;
   longint ref_q[4];
   longint err_hold[3];
   longint fin_hold[4];
   logic [103:0] pending[$];
   int fails = 0;
   bit stall_free = 0;

   function automatic longint sra(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint rnd_up(longint v, int n);
      if (n == 0) return v;
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint rnd_away(longint v, int n);
      if (v >= 0) return rnd_up(v, n);
      return -rnd_up(-v, n);
   endfunction

   function automatic longint lim(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v -= res + bt;
            res = (res >> 1) + bt;
         end else res >>= 1;
         bt >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 180 * 32768 : -180 * 32768;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = sra(y, i);
         dy = sra(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(aefm_pkg::atan_step(i[4:0]));
         end else begin
            x -= dx; y += dy; z -= longint'(aefm_pkg::atan_step(i[4:0]));
         end
      end
      return z;
   endfunction

   function automatic longint unsigned fin(longint v);
      return longint'(lim(v, 500, 2500));
   endfunction

   task automatic predict_tick(input logic [71:0] d);
      longint im[4], qw, qx, qy, qz, w, x, y, z, one, sr, cr, sp, sy, cy, r, p, yw, o, s;
      longint unsigned mg;
      aefm_pkg::mode_type rq;
      rq = aefm_pkg::mode_type'(d[1:0]);
      for (int k = 0; k < 4; k++) im[k] = longint'($signed(d[2 + 16*k +: 16]));
      if (rq == aefm_pkg::MODE_INIT) begin
         if (mode_now != aefm_pkg::MODE_INIT) for (int k = 0; k < 4; k++) ref_q[k] = im[k];
      end else if (rq == aefm_pkg::MODE_ASCENT) begin
         qw = ref_q[0]; qx = -ref_q[1]; qy = -ref_q[2]; qz = -ref_q[3];
         w = rnd_up(im[0]*qw - im[1]*qx - im[2]*qy - im[3]*qz, FR);
         x = rnd_up(im[0]*qx + im[1]*qw - im[2]*qz + im[3]*qy, FR);
         y = rnd_up(im[0]*qy + im[1]*qz + im[2]*qw - im[3]*qx, FR);
         z = rnd_up(im[0]*qz - im[1]*qy + im[2]*qx + im[3]*qw, FR);
         one = longint'(1) << (2*FR);
         sr = 2*(w*x + y*z);
         cr = one - 2*(x*x + y*y);
         sp = 2*(w*y - z*x);
         sy = 2*(w*z + x*y);
         cy = one - 2*(y*y + z*z);
         r = lim(rnd_up(vector_angle(sr, cr), 8), -23040, 23040);
         yw = lim(rnd_up(vector_angle(sy, cy), 8), -23040, 23040);
         if (sp >= one) p = 11520;
         else if (sp <= -one) p = -11520;
         else begin
            s = sp * (longint'(1) << (30 - 2*FR));
            mg = longint'(s < 0 ? -s : s);
            p = lim(rnd_up(vector_angle(s, int_sqrt((64'd1 << 60) - mg*mg)), 8),
                    -11520, 11520);
         end
         err_hold[0] = r; err_hold[1] = p; err_hold[2] = yw;
         o = rnd_away(gain_us * r, 7);
         fin_hold[0] = fin(neutral_us + o);
         fin_hold[1] = fin(neutral_us - o);
         o = rnd_away(gain_us * p, 7);
         fin_hold[2] = fin(neutral_us + o);
         fin_hold[3] = fin(neutral_us - o);
      end
      mode_now = rq;
      pending.push_back({fin_hold[3][11:0], fin_hold[2][11:0], fin_hold[1][11:0],
                         fin_hold[0][11:0], err_hold[2][15:0], err_hold[1][14:0],
                         err_hold[0][15:0], 2'(mode_now)});
   endtask

   function automatic int gap_len();
      int c;
      c = $urandom_range(0, 99);
      if (c < 50) return 0;
      if (c < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_tick(input aefm_pkg::mode_type m, input logic [15:0] w,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
      logic [71:0] d;
      int g;
      d = {6'd0, z, y, x, w, 2'(m)};
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tick(d);
   endtask

   // check each result transfer
   always @(posedge clock) begin
      logic [103:0] exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_tdata);
            fails++;
         end else begin
            exp_r = pending.pop_front();
            if (exp_r[1:0] != rsp_tdata[1:0] || exp_r[17:2] != rsp_tdata[17:2] ||
                exp_r[32:18] != rsp_tdata[32:18] || exp_r[48:33] != rsp_tdata[48:33] ||
                exp_r[60:49] != rsp_tdata[60:49] || exp_r[72:61] != rsp_tdata[72:61] ||
                exp_r[84:73] != rsp_tdata[84:73] || exp_r[96:85] != rsp_tdata[96:85]) begin
               $display("%0t mismatch expected %h actual %h", $time, exp_r, rsp_tdata);
               fails++;
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (stall_free) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 99) < 70);
   end

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [10:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == aefm_pkg::CSR_NEUTRAL) neutral_us = v;
      else gain_us = v[3:0];
   endtask

   function automatic logic [15:0] rq_comp();
      int c;
      c = $urandom_range(0, 9);
      if (c == 0) return 16'(16384);
      if (c == 1) return 16'(-16384);
      if (c == 2) return 16'($urandom_range(0, 65535));
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   task automatic test_directed();
      send_tick(aefm_pkg::MODE_ASCENT, 16'd16384, 16'd0, 16'd0, 16'd0);
      send_tick(aefm_pkg::MODE_INIT, 16'd11585, 16'd11585, 16'd0, 16'd0);
      send_tick(aefm_pkg::MODE_INIT, 16'd16384, 16'd0, 16'd0, 16'd0);
      send_tick(aefm_pkg::MODE_ASCENT, 16'd16384, 16'd0, 16'd0, 16'd0);
      send_tick(aefm_pkg::MODE_ASCENT, 16'd11585, 16'd0, 16'd11585, 16'd0);
      send_tick(aefm_pkg::MODE_ASCENT, 16'd11585, 16'd0, -16'sd11585, 16'd0);
      send_tick(aefm_pkg::MODE_ASCENT, 16'd0, 16'd16384, 16'd0, 16'd0);
      send_tick(aefm_pkg::MODE_ASCENT, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(aefm_pkg::MODE_ASCENT, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_tick(aefm_pkg::MODE_ASCENT, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_tick(aefm_pkg::MODE_SAFE, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
      send_tick(aefm_pkg::MODE_EMPTY, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_tick(aefm_pkg::MODE_INIT, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_tick(aefm_pkg::MODE_ASCENT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_tick(aefm_pkg::MODE_ASCENT, 16'd0, 16'd0, 16'd0, 16'd16384);
      drain();
      write_reg(aefm_pkg::CSR_NEUTRAL, 11'd2000);
      send_tick(aefm_pkg::MODE_SAFE, 16'd0, 16'd0, 16'd0, 16'd0);
      drain();
   endtask

   task automatic test_random(input int n);
      int c;
      aefm_pkg::mode_type m;
      for (int i = 0; i < n; i++) begin
         c = $urandom_range(0, 99);
         if (c < 10) m = aefm_pkg::MODE_INIT;
         else if (c < 80) m = aefm_pkg::MODE_ASCENT;
         else if (c < 90) m = aefm_pkg::MODE_SAFE;
         else m = aefm_pkg::MODE_EMPTY;
         send_tick(m, rq_comp(), rq_comp(), rq_comp(), rq_comp());
      end
   endtask

   task automatic test_settings();
      int s;
      for (int ph = 0; ph < 8; ph++) begin
         s = ph % 4;
         write_reg(aefm_pkg::CSR_NEUTRAL, s == 0 ? 11'd1000 : s == 1 ? 11'd2000 :
                   s == 2 ? 11'd2047 : 11'($urandom_range(1000, 2000)));
         write_reg(aefm_pkg::CSR_GAIN, s == 0 ? 11'd0 : s == 1 ? 11'd8 : s == 2 ? 11'd15 :
                   11'($urandom_range(0, 8)));
         stall_free = (ph == 3);
         test_random(150);
         drain();
      end
      stall_free = 0;
   endtask

   initial begin
      neutral_us = 1500; gain_us = 2; mode_now = aefm_pkg::MODE_EMPTY;
      ref_q[0] = 16384; ref_q[1] = 0; ref_q[2] = 0; ref_q[3] = 0;
      err_hold[0] = 0; err_hold[1] = 0; err_hold[2] = 0;
      for (int k = 0; k < 4; k++) fin_hold[k] = 1500;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings();
      write_reg(aefm_pkg::CSR_NEUTRAL, 11'd1500);
      write_reg(aefm_pkg::CSR_GAIN, 11'd2);
      test_random(60);
      drain();
      if (fails == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
